>>> design/dro_pkg.sv
`timescale 1ns / 1ps

package dro_pkg;

    localparam int DEPTH_DEF = 32;

    localparam int ACT_W  = 2;
    localparam int KEY_W  = 64;
    localparam int PL_W   = 64;
    localparam int ST_W   = 3;
    localparam int OCC_W  = 6;

    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP = 2'd1;

    localparam logic [ST_W-1:0] ST_STORED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_POPPED  = 3'd3;
    localparam logic [ST_W-1:0] ST_NOMATCH = 3'd4;
    localparam logic [ST_W-1:0] ST_STATUS  = 3'd5;

endpackage

>>> design/dedup_ring_outbox_core.sv
`timescale 1ns / 1ps

// channel   ports                                      handshake
// --------  -----------------------------------------  ------------------------------
// command   i_action i_key i_payload                   taken when start & !busy
// result    o_status o_occupancy o_head_valid          shown one cycle with o_strobe
//           o_head_key o_head_payload
//
// enqueue: the result waits for the key search, which reads one stored key per cycle;
//   a duplicate hit on an older entry ends it sooner
// pop: head key read, compare, head read, output; status: head read, output
// a new command is taken in the strobe cycle
// synchronous active-low reset clears pointers and count, no memory clearing
// the receiver cannot stall, results are never held
module dedup_ring_outbox_core #(
    parameter int DEPTH = dro_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dro_pkg::ACT_W-1:0]  i_action,
    input  logic [dro_pkg::KEY_W-1:0]  i_key,
    input  logic [dro_pkg::PL_W-1:0]   i_payload,
    output logic                       o_strobe,
    output logic [dro_pkg::ST_W-1:0]   o_status,
    output logic [dro_pkg::OCC_W-1:0]  o_occupancy,
    output logic                       o_head_valid,
    output logic [dro_pkg::KEY_W-1:0]  o_head_key,
    output logic [dro_pkg::PL_W-1:0]   o_head_payload
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP_CMP,
        S_HEAD_RD,
        S_HEAD_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [PW-1:0]              r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]              r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_issued, n_issued;
    logic                       r_pend, n_pend;
    logic [dro_pkg::KEY_W-1:0]  r_key, n_key;
    logic [dro_pkg::PL_W-1:0]   r_payload, n_payload;
    logic [dro_pkg::ST_W-1:0]   r_status, n_status;

    logic [dro_pkg::KEY_W-1:0]  key_mem [DEPTH];
    logic [dro_pkg::PL_W-1:0]   pl_mem  [DEPTH];
    logic [dro_pkg::KEY_W-1:0]  r_key_q;
    logic [dro_pkg::PL_W-1:0]   r_pl_q;

    logic [PW-1:0]              w_rd_addr;
    logic                       w_we;
    logic [PW:0]                w_sum;
    logic [PW-1:0]              w_scan_addr;
    logic                       w_hit;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_sum       = {1'b0, r_rd_ptr} + {1'b0, r_issued[PW-1:0]};
    assign w_scan_addr = (w_sum >= (PW+1)'(DEPTH)) ? PW'(w_sum - (PW+1)'(DEPTH))
                                                   : w_sum[PW-1:0];
    assign w_hit       = r_pend && (r_key_q == r_key);
    assign busy        = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_issued  = r_issued;
        n_pend    = 1'b0;
        n_key     = r_key;
        n_payload = r_payload;
        n_status  = r_status;
        w_rd_addr = r_rd_ptr;
        w_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key     = i_key;
                    n_payload = i_payload;
                    n_issued  = '0;
                    if (i_action == dro_pkg::ACT_ENQ) begin
                        n_state = S_SCAN;
                    end else if (i_action == dro_pkg::ACT_POP) begin
                        n_state = S_POP_CMP;
                    end else begin
                        n_status = dro_pkg::ST_STATUS;
                        n_state  = S_HEAD_RD;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_status = dro_pkg::ST_DUP;
                    n_state  = S_HEAD_RD;
                end else if (r_issued == r_count) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = dro_pkg::ST_FULL;
                    end else begin
                        w_we     = 1'b1;
                        n_wr_ptr = ptr_inc(r_wr_ptr);
                        n_count  = r_count + 1'b1;
                        n_status = dro_pkg::ST_STORED;
                    end
                    n_state = S_HEAD_RD;
                end else begin
                    w_rd_addr = w_scan_addr;
                    n_issued  = r_issued + 1'b1;
                    n_pend    = 1'b1;
                end
            end
            S_POP_CMP: begin
                if (r_count != '0 && r_key_q == r_key) begin
                    n_rd_ptr = ptr_inc(r_rd_ptr);
                    n_count  = r_count - 1'b1;
                    n_status = dro_pkg::ST_POPPED;
                end else begin
                    n_status = dro_pkg::ST_NOMATCH;
                end
                n_state = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_OUT;
            end
            S_HEAD_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            key_mem[r_wr_ptr] <= r_key;
            pl_mem[r_wr_ptr]  <= r_payload;
        end
        r_key_q <= key_mem[w_rd_addr];
        r_pl_q  <= pl_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_issued <= '0;
            r_pend   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_issued <= n_issued;
            r_pend   <= n_pend;
            o_strobe <= (r_state == S_HEAD_OUT);
        end
        r_key     <= n_key;
        r_payload <= n_payload;
        r_status  <= n_status;
        if (r_state == S_HEAD_OUT) begin
            o_status       <= r_status;
            o_occupancy    <= dro_pkg::OCC_W'(r_count);
            o_head_valid   <= (r_count != '0);
            o_head_key     <= (r_count != '0) ? r_key_q : '0;
            o_head_payload <= (r_count != '0) ? r_pl_q : '0;
        end
    end

endmodule

>>> design/dro_checker.sv
`timescale 1ns / 1ps

module dro_checker #(
    parameter int DEPTH = dro_pkg::DEPTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_strobe,
    input logic [dro_pkg::ST_W-1:0]   o_status,
    input logic [dro_pkg::OCC_W-1:0]  o_occupancy,
    input logic                       o_head_valid,
    input logic [dro_pkg::KEY_W-1:0]  o_head_key,
    input logic [dro_pkg::PL_W-1:0]   o_head_payload
);

    localparam int MIN_DEPTH = 2;

    a_depth_ok: assert property (@(posedge i_clk) DEPTH >= MIN_DEPTH)
        else $error("depth below minimum");

    a_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && !$past(o_strobe))
        else $error("result word while busy or strobe held");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_head_valid |->
            o_head_key == '0 && o_head_payload == '0 && o_occupancy == '0)
        else $error("empty result word with nonzero head");

    a_stored_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == dro_pkg::ST_STORED || o_status == dro_pkg::ST_DUP)
            |-> o_head_valid)
        else $error("stored or duplicate word with empty fifo");

endmodule

bind dedup_ring_outbox_core dro_checker #(.DEPTH(DEPTH)) u_dro_checker (.*);
